>>> src/f9c_pkg.sv
// ----------------------------------------------------------------------------
// f9c_pkg
// Shared types and constants of the FAST-9 corner detector: line store
// geometry, circle offsets, register indexes and reset values.
// ----------------------------------------------------------------------------
package f9c_pkg;

   localparam int LINE_PIXELS   = 1024;
   localparam int LINE_LIMIT    = (LINE_PIXELS < 1024) ? LINE_PIXELS : 1024;
   localparam int ADDR_W        = $clog2(LINE_PIXELS);
   localparam int LINE_ROWS     = 6;
   localparam int WIN           = 7;
   localparam int CIRCLE_POINTS = 16;
   localparam int ARC_NEEDED    = 9;
   localparam int EDGE_MARGIN   = 3;
   localparam int PIXEL_W       = 8;
   localparam int COORD_W       = 10;
   localparam int DIM_W         = 11;
   localparam int SCORE_W       = 5;
   localparam int COUNT_W       = 16;
   localparam int CSR_INDEX_W   = 2;
   localparam int CSR_DATA_W    = 16;
   localparam int HEIGHT_LIMIT  = 1024;

   // circle offsets, column then row, counterclockwise from straight below
   localparam int RING_DX [CIRCLE_POINTS] =
      '{0, 1, 2, 3, 3, 3, 2, 1, 0, -1, -2, -3, -3, -3, -2, -1};
   localparam int RING_DY [CIRCLE_POINTS] =
      '{3, 3, 2, 1, 0, -1, -2, -3, -3, -3, -2, -1, 0, 1, 2, 3};

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_THRESHOLD = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_WIDTH     = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_HEIGHT    = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_CAP       = 2'd3;

   localparam logic [PIXEL_W-1:0] THRESHOLD_RESET = 8'd31;
   localparam logic [DIM_W-1:0]   WIDTH_RESET     = 11'd800;
   localparam logic [DIM_W-1:0]   HEIGHT_RESET    = 11'd640;
   localparam logic [COUNT_W-1:0] CAP_RESET       = 16'd500;

   typedef logic [PIXEL_W-1:0]           pixel_type;
   typedef logic [CIRCLE_POINTS-1:0]     mask_type;
   typedef logic [LINE_ROWS*PIXEL_W-1:0] column_type;

   typedef struct packed {
      logic                 tested;
      logic                 clear_before;
      logic                 clear_after;
      logic [COORD_W-1:0]   x;
      logic [COORD_W-1:0]   y;
   } meta_type;

   typedef struct packed {
      logic               hit;
      logic [SCORE_W-1:0] score;
   } eval_type;

endpackage

>>> src/f9c_stream_if.sv
// ----------------------------------------------------------------------------
// f9c stream interfaces
// Valid/ready channels for the pixel input and the corner output.
// ----------------------------------------------------------------------------
interface f9c_req_if;
   logic                        valid;
   logic                        ready;
   logic [f9c_pkg::PIXEL_W-1:0] gray_pixel;
   logic                        frame_start;

   modport source (output valid, output gray_pixel, output frame_start, input ready);
   modport sink   (input valid, input gray_pixel, input frame_start, output ready);
endinterface

interface f9c_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [f9c_pkg::COORD_W-1:0] corner_x;
   logic [f9c_pkg::COORD_W-1:0] corner_y;
   logic [f9c_pkg::SCORE_W-1:0] corner_score;
   logic [f9c_pkg::COUNT_W-1:0] corner_index;

   modport source (output valid, output corner_x, output corner_y, output corner_score,
                   output corner_index, input ready);
   modport sink   (input valid, input corner_x, input corner_y, input corner_score,
                   input corner_index, output ready);
endinterface

>>> src/f9c_arc_eval.sv
// ----------------------------------------------------------------------------
// f9c_arc_eval
// Finds a contiguous circular arc of nine bright or nine dark circle pixels
// and gives the score, the larger of the bright and dark counts.
// ----------------------------------------------------------------------------
module f9c_arc_eval (
   input  f9c_pkg::mask_type bright_mask,
   input  f9c_pkg::mask_type dark_mask,
   output f9c_pkg::eval_type result
);

   logic [2*f9c_pkg::CIRCLE_POINTS-1:0] bright_twice;
   logic [2*f9c_pkg::CIRCLE_POINTS-1:0] dark_twice;
   logic [f9c_pkg::CIRCLE_POINTS-1:0]   bright_run;
   logic [f9c_pkg::CIRCLE_POINTS-1:0]   dark_run;
   logic [f9c_pkg::SCORE_W-1:0]         bright_count;
   logic [f9c_pkg::SCORE_W-1:0]         dark_count;

   assign bright_twice = {bright_mask, bright_mask};
   assign dark_twice   = {dark_mask, dark_mask};

   // one arc test per start position, wrapping through the doubled mask
   always_comb begin
      for (int s = 0; s < f9c_pkg::CIRCLE_POINTS; s++) begin
         bright_run[s] = &bright_twice[s +: f9c_pkg::ARC_NEEDED];
         dark_run[s]   = &dark_twice[s +: f9c_pkg::ARC_NEEDED];
      end
   end

   assign bright_count = f9c_pkg::SCORE_W'($countones(bright_mask));
   assign dark_count   = f9c_pkg::SCORE_W'($countones(dark_mask));

   assign result.hit   = (|bright_run) | (|dark_run);
   assign result.score = (bright_count > dark_count) ? bright_count : dark_count;

endmodule

>>> src/fast9_corner_detector_core.sv
// ----------------------------------------------------------------------------
// fast9_corner_detector_core
// FAST-9 corner detection on a raster pixel stream with a 6-line column store
// and a 7x7 window.
// ----------------------------------------------------------------------------
// path: a pixel word passes the stage 1, stage 2 and output word registers before its corner word
// throughput: one pixel per cycle while the output is not stalled, set by the line store's
//    one read and one write port; the column written in the same cycle is forwarded
// reset: registers return to defaults, counters and window clear, the line
//    store is not cleared (its lines refill during the first six rows)
module fast9_corner_detector_core (
   input  logic                                 clock,
   input  logic                                 reset,
   f9c_req_if.sink                              req_stream,
   f9c_rsp_if.source                            rsp_stream,
   input  logic                                 csr_wr_en,
   input  logic [f9c_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [f9c_pkg::CSR_DATA_W-1:0]       csr_wr_data
);

   localparam int PW = f9c_pkg::PIXEL_W;
   localparam int CW = f9c_pkg::COORD_W;
   localparam int DW = f9c_pkg::DIM_W;
   localparam int NW = f9c_pkg::WIN;
   localparam int NR = f9c_pkg::LINE_ROWS;
   localparam int NC = f9c_pkg::CIRCLE_POINTS;
   localparam int CTR = (f9c_pkg::WIN - 1) / 2;

   // configuration
   logic [PW-1:0]                thr_ff;
   logic [DW-1:0]                width_ff;
   logic [DW-1:0]                height_ff;
   logic [f9c_pkg::COUNT_W-1:0]  cap_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff    <= f9c_pkg::THRESHOLD_RESET;
         width_ff  <= f9c_pkg::WIDTH_RESET;
         height_ff <= f9c_pkg::HEIGHT_RESET;
         cap_ff    <= f9c_pkg::CAP_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            f9c_pkg::REG_THRESHOLD: thr_ff    <= csr_wr_data[PW-1:0];
            f9c_pkg::REG_WIDTH:     width_ff  <= csr_wr_data[DW-1:0];
            f9c_pkg::REG_HEIGHT:    height_ff <= csr_wr_data[DW-1:0];
            f9c_pkg::REG_CAP:       cap_ff    <= csr_wr_data;
         endcase
      end
   end

   // pipeline control
   logic s1_valid_ff, s2_valid_ff, out_valid_ff;
   logic out_free, s2_go, s2_free, s1_go, s1_free, accept;

   assign out_free = !out_valid_ff || rsp_stream.ready;
   assign s2_go    = s2_valid_ff && out_free;
   assign s2_free  = !s2_valid_ff || out_free;
   assign s1_go    = s1_valid_ff && s2_free;
   assign s1_free  = !s1_valid_ff || s2_free;
   assign req_stream.ready = s1_free;
   assign accept   = req_stream.valid && s1_free;

   // position counters
   logic [CW-1:0]  col_ff, row_ff, col_in, row_in, col_cur, row_cur;
   logic [DW-1:0]  w_eff, h_eff, col_next, row_next;
   logic           end_line, end_frame, tested;
   f9c_pkg::meta_type meta_in;

   always_comb begin
      if (width_ff == '0) w_eff = DW'(1);
      else if (width_ff > DW'(f9c_pkg::LINE_LIMIT)) w_eff = DW'(f9c_pkg::LINE_LIMIT);
      else w_eff = width_ff;
      if (height_ff == '0) h_eff = DW'(1);
      else if (height_ff > DW'(f9c_pkg::HEIGHT_LIMIT)) h_eff = DW'(f9c_pkg::HEIGHT_LIMIT);
      else h_eff = height_ff;

      col_cur = req_stream.frame_start ? '0 : col_ff;
      row_cur = req_stream.frame_start ? '0 : row_ff;
      if ({1'b0, col_cur} >= w_eff) col_cur = '0;

      tested = (col_cur >= CW'(NR)) && (row_cur >= CW'(NR))
               && ({1'b0, row_cur} < h_eff);

      col_next  = {1'b0, col_cur} + DW'(1);
      row_next  = {1'b0, row_cur} + DW'(1);
      end_line  = col_next >= w_eff;
      end_frame = end_line && (row_next >= h_eff);
      col_in    = end_line ? '0 : col_next[CW-1:0];
      if (!end_line) row_in = row_cur;
      else if (end_frame) row_in = '0;
      else row_in = row_next[CW-1:0];

      meta_in.tested       = tested;
      meta_in.clear_before = req_stream.frame_start;
      meta_in.clear_after  = end_frame;
      meta_in.x            = col_cur - CW'(f9c_pkg::EDGE_MARGIN);
      meta_in.y            = row_cur - CW'(f9c_pkg::EDGE_MARGIN);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // line store: one column of six past lines per entry
   f9c_pkg::column_type line_mem [f9c_pkg::LINE_PIXELS];
   f9c_pkg::column_type rd_data_ff, last_wr_ff, wr_word;
   logic [f9c_pkg::ADDR_W-1:0] rd_addr, s1_addr_ff;
   logic                       fwd_in;

   assign rd_addr = col_cur[f9c_pkg::ADDR_W-1:0];
   // the word in stage 1 is written at the same edge as this read
   assign fwd_in  = s1_valid_ff && (s1_addr_ff == rd_addr);

   always_ff @(posedge clock) begin
      if (accept) begin
         rd_data_ff <= line_mem[rd_addr];
      end
      if (s1_go) begin
         line_mem[s1_addr_ff] <= wr_word;
      end
   end

   // stage 1: column assembly, window shift, contrast tests
   f9c_pkg::pixel_type  s1_pix_ff;
   logic                s1_fwd_ff;
   f9c_pkg::meta_type   s1_meta_ff;
   f9c_pkg::column_type col_old;
   f9c_pkg::pixel_type  colv [NW];
   f9c_pkg::pixel_type  win_ff [NW][NW];
   f9c_pkg::pixel_type  win_in [NW][NW];
   f9c_pkg::pixel_type  center, ring_pix;
   logic [PW:0]         upper, ring_plus;
   f9c_pkg::mask_type   bright_in, dark_in;

   always_comb begin
      col_old = s1_fwd_ff ? last_wr_ff : rd_data_ff;
      for (int r = 0; r < NR; r++) begin
         colv[r] = col_old[r*PW +: PW];
      end
      colv[NW-1] = s1_pix_ff;
      for (int r = 0; r < NR; r++) begin
         wr_word[r*PW +: PW] = colv[r+1];
      end
      for (int r = 0; r < NW; r++) begin
         for (int c = 0; c < NW-1; c++) begin
            win_in[r][c] = win_ff[r][c+1];
         end
         win_in[r][NW-1] = colv[r];
      end

      center = win_in[CTR][CTR];
      upper  = {1'b0, center} + {1'b0, thr_ff};
      for (int i = 0; i < NC; i++) begin
         ring_pix     = win_in[CTR + f9c_pkg::RING_DY[i]][CTR + f9c_pkg::RING_DX[i]];
         ring_plus    = {1'b0, ring_pix} + {1'b0, thr_ff};
         bright_in[i] = {1'b0, ring_pix} > upper;
         dark_in[i]   = ring_plus < {1'b0, center};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_free) begin
         s1_valid_ff <= accept;
      end
      if (accept) begin
         s1_pix_ff  <= req_stream.gray_pixel;
         s1_addr_ff <= rd_addr;
         s1_fwd_ff  <= fwd_in;
         s1_meta_ff <= meta_in;
      end
      if (s1_go) begin
         last_wr_ff <= wr_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < NW; r++) begin
            for (int c = 0; c < NW; c++) begin
               win_ff[r][c] <= '0;
            end
         end
      end else if (s1_go) begin
         win_ff <= win_in;
      end
   end

   // stage 2: arc test, score and per-frame corner cap
   f9c_pkg::mask_type   bright_ff, dark_ff;
   f9c_pkg::meta_type   s2_meta_ff;
   f9c_pkg::eval_type   eval;
   logic [f9c_pkg::COUNT_W-1:0] found_ff, found_cur, found_in;
   logic                emit;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_free) begin
         s2_valid_ff <= s1_go;
      end
      if (s1_go) begin
         bright_ff  <= bright_in;
         dark_ff    <= dark_in;
         s2_meta_ff <= s1_meta_ff;
      end
   end

   f9c_arc_eval u_arc_eval (
      .bright_mask (bright_ff),
      .dark_mask   (dark_ff),
      .result      (eval)
   );

   always_comb begin
      found_cur = s2_meta_ff.clear_before ? '0 : found_ff;
      emit      = s2_meta_ff.tested && eval.hit && (found_cur < cap_ff);
      found_in  = emit ? found_cur + f9c_pkg::COUNT_W'(1) : found_cur;
      if (s2_meta_ff.clear_after) found_in = '0;
   end

   // output word register
   logic [CW-1:0]               out_x_ff, out_y_ff;
   logic [f9c_pkg::SCORE_W-1:0] out_score_ff;
   logic [f9c_pkg::COUNT_W-1:0] out_index_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (s2_go) begin
            found_ff <= found_in;
         end
         if (out_free) begin
            out_valid_ff <= s2_go && emit;
         end
      end
      if (s2_go && emit) begin
         out_x_ff     <= s2_meta_ff.x;
         out_y_ff     <= s2_meta_ff.y;
         out_score_ff <= eval.score;
         out_index_ff <= found_cur;
      end
   end

   assign rsp_stream.valid        = out_valid_ff;
   assign rsp_stream.corner_x     = out_x_ff;
   assign rsp_stream.corner_y     = out_y_ff;
   assign rsp_stream.corner_score = out_score_ff;
   assign rsp_stream.corner_index = out_index_ff;

endmodule
